// ===== rtl/core/wtosc_pkg.sv =====
// Wavetable oscillator package: request and result layouts, field widths, command codes.
// No dependencies; imported by the oscillator top level.
`default_nettype none

package wtosc_pkg;

  // Field widths
  localparam int WAVE_NUM_W = 4;
  localparam int TADDR_W    = 8;
  localparam int SAMPLE_W   = 16;
  localparam int SPEED_W    = 24;
  localparam int GAIN_W     = 9;

  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 40;

  // Command codes carried in tuser
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_RENDER = 1'b1;

  // Input request, last field in the lowest bits
  typedef struct packed {
    logic [3:0]                 pad;
    logic signed [SAMPLE_W-1:0] mix_in;
    logic [WAVE_NUM_W-1:0]      queued_number;
    logic                       queue_wave;
    logic                       set_wave;
    logic                       enable;
    logic [GAIN_W-1:0]          gain;
    logic [SPEED_W-1:0]         speed;
    logic signed [SAMPLE_W-1:0] table_data;
    logic [TADDR_W-1:0]         table_addr;
    logic [WAVE_NUM_W-1:0]      wave_number;
  } in_req_t;

  // Result, last field in the lowest bits
  typedef struct packed {
    logic [6:0]                 pad;
    logic                       wrapped;
    logic signed [SAMPLE_W-1:0] mix_out;
    logic signed [SAMPLE_W-1:0] sample;
  } out_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/oversampled_wavetable_oscillator_top.sv =====
// Oversampled wavetable oscillator: wave table memory, phase sequencer, gain scaling.
// Depends on wtosc_pkg.
//
// Usage:
//   Requests enter on the in_ stream; in_tuser selects the command. A write request
//   stores one signed word into the wave table and gives no result. A render request
//   optionally sets and queues waves, reads the table OVERSAMPLE times while the phase
//   advances, scales the sum by gain and adds it to mix_in. One result leaves on the
//   out_ stream per render request.
// Timing:
//   A write request leaves the sequencer idle, so in_tready stays high. A render request
//   holds in_tready low until its result is loaded into the output register; in between
//   it passes the single table read port (one read per oversampled step) and the drain,
//   multiply, scale and output stages. When PHASE_RESOLUTION*OVERSAMPLE or WAVE_LENGTH
//   is not a power of two, the speed is first split by a shared restoring divider of
//   DIV_W = 26 + OVERSAMPLE_LOG2 bits; when VOLUME_RESOLUTION*OVERSAMPLE is not a power
//   of two the scaling uses the same divider.
// Reset:
//   rst_n clears phase, current and queued wave and all handshake state. The table is
//   not cleared; words must be written before they are read.
// Stall:
//   The result sits in an output register; the next request is taken while it waits.
//   A finished result that finds the register full holds the sequencer until it drains.
`default_nettype none

module oversampled_wavetable_oscillator_top
  import wtosc_pkg::*;
#(
  parameter int WAVE_COUNT        = 16,
  parameter int WAVE_LENGTH       = 256,
  parameter int PHASE_RESOLUTION  = 256,
  parameter int OVERSAMPLE_LOG2   = 2,
  parameter int VOLUME_RESOLUTION = 256
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // in_tdata: wave_number, table_addr, table_data, speed, gain, enable, set_wave,
  //           queue_wave, queued_number, mix_in, zero pad (lowest bit first)
  input  wire logic                   in_tvalid,
  output      logic                   in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // in_tuser: cmd
  input  wire logic [0:0]             in_tuser,
  // out_tdata: sample, mix_out, wrapped, zero pad (lowest bit first)
  output      logic                   out_tvalid,
  input  wire logic                   out_tready,
  output      logic [OUT_TDATA_W-1:0] out_tdata
);

  // Derived sizes
  localparam int OS        = 1 << OVERSAMPLE_LOG2;
  localparam int CNT_W     = (OVERSAMPLE_LOG2 > 0) ? OVERSAMPLE_LOG2 : 1;
  localparam int STEP_DIV  = PHASE_RESOLUTION * OS;
  localparam int VOL_DIV   = VOLUME_RESOLUTION * OS;
  localparam int FRAC_W    = (STEP_DIV > 1) ? $clog2(STEP_DIV) : 1;
  localparam int FRAC_SH   = $clog2(STEP_DIV);
  localparam int VOL_SH    = $clog2(VOL_DIV);
  localparam int IDX_W     = $clog2(WAVE_LENGTH);
  localparam int MEM_DEPTH = WAVE_COUNT * WAVE_LENGTH;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam bit STEP_POW2 = (STEP_DIV & (STEP_DIV - 1)) == 0;
  localparam bit WL_POW2   = (WAVE_LENGTH & (WAVE_LENGTH - 1)) == 0;
  localparam bit FAST_SPD  = STEP_POW2 && WL_POW2;
  localparam bit VOL_POW2  = (VOL_DIV & (VOL_DIV - 1)) == 0;
  localparam int SUM_W     = SAMPLE_W + OVERSAMPLE_LOG2;
  localparam int PROD_W    = SUM_W + GAIN_W + 1;
  localparam int DIV_W     = (PROD_W > SPEED_W) ? PROD_W : SPEED_W;
  localparam int DCNT_W    = $clog2(DIV_W);
  localparam int DVS_MAX   = (STEP_DIV > VOL_DIV) ? STEP_DIV : VOL_DIV;
  localparam int DVS_W     = $clog2(DVS_MAX + 1);

  localparam logic signed [DIV_W:0] SAT_HI = (DIV_W + 1)'(32767);
  localparam logic signed [DIV_W:0] SAT_LO = -(DIV_W + 1)'(32768);

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SPDIV = 3'd1;
  localparam logic [2:0] S_RUN   = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_SCALE = 3'd5;
  localparam logic [2:0] S_VDIV  = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  in_req_t  req;
  out_res_t res;

  logic [2:0] state_r, state_nxt;
  logic       in_acc, out_load;

  // Oscillator state
  logic [IDX_W-1:0]      idx_r;
  logic [FRAC_W-1:0]     frac_r;
  logic [WAVE_NUM_W-1:0] cur_r, pend_r;

  // Per-request operands
  logic [IDX_W-1:0]           sidx_r;
  logic [FRAC_W-1:0]          sfrac_r;
  logic                       sbig_r;
  logic [GAIN_W-1:0]          gain_r;
  logic                       en_r;
  logic signed [SAMPLE_W-1:0] mix_r;
  logic                       wrap_r;
  logic [CNT_W-1:0]           cnt_r;

  // Table memory
  logic signed [SAMPLE_W-1:0] wave_mem_r [MEM_DEPTH];
  logic signed [SAMPLE_W-1:0] rd_data_r;
  logic                       rd_vld_r, rd_ok_r;
  logic                       rd_en, wr_en;
  logic [ADDR_W-1:0]          rd_addr, wr_addr;

  // Datapath
  logic signed [SUM_W-1:0]    acc_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [GAIN_W:0]     gain_s;
  logic                       neg_r;
  logic signed [SAMPLE_W-1:0] res_smp_r;

  // Shared restoring divider
  logic [DIV_W-1:0]  div_num_r, div_q_r, div_q_nxt;
  logic [DVS_W-1:0]  div_rem_r, div_rem_nxt, div_dvs;
  logic [IDX_W-1:0]  div_qm_r, div_qm_nxt;
  logic              div_big_r, div_vol_r, div_ge, div_qge;
  logic [DVS_W:0]    div_rsh;
  logic [IDX_W:0]    div_qsh;
  logic [DCNT_W-1:0] div_cnt_r;

  // Phase step logic
  logic [FRAC_W:0]      fsum;
  logic                 carry;
  logic [FRAC_W-1:0]    frac_nxt;
  logic [IDX_W:0]       isum;
  logic                 wrap_i, step_wrap;
  logic [IDX_W-1:0]     idx_nxt;

  // Fast speed split
  logic [SPEED_W-1:0]   spd_q_fast;
  logic [IDX_W-1:0]     sidx_fast;
  logic [FRAC_W-1:0]    sfrac_fast;
  logic                 sbig_fast;

  // Scaling
  logic signed [PROD_W-1:0] vbias, vq_fast;
  logic [PROD_W-1:0]        mag;
  logic signed [DIV_W:0]    q_signed, sat_in;
  logic signed [SAMPLE_W-1:0] sat_out;

  assign req        = in_req_t'(in_tdata);
  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_load   = (state_r == S_OUT) && (!out_tvalid || out_tready);

  // Table write port
  assign wr_en   = in_acc && (in_tuser[0] == CMD_WRITE) &&
                   (32'(req.wave_number) < WAVE_COUNT) &&
                   (32'(req.table_addr) < WAVE_LENGTH);
  assign wr_addr = ADDR_W'(32'(req.wave_number) * WAVE_LENGTH + 32'(req.table_addr));

  // Table read port, one read per oversampled step
  assign rd_en   = (state_r == S_RUN);
  assign rd_addr = ADDR_W'(32'(cur_r) * WAVE_LENGTH + 32'(idx_r));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      wave_mem_r[wr_addr] <= req.table_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= wave_mem_r[rd_addr];
    end
  end

  // Speed split when both divisors are powers of two
  always_comb begin
    spd_q_fast = req.speed >> FRAC_SH;
    sidx_fast  = IDX_W'(spd_q_fast);
    sfrac_fast = FRAC_W'(req.speed & SPEED_W'(STEP_DIV - 1));
    sbig_fast  = (spd_q_fast >> IDX_W) != '0;
  end

  // Phase advance: fraction then word index, each with one conditional subtract
  always_comb begin
    fsum      = {1'b0, frac_r} + {1'b0, sfrac_r};
    carry     = fsum >= (FRAC_W + 1)'(STEP_DIV);
    frac_nxt  = carry ? FRAC_W'(fsum - (FRAC_W + 1)'(STEP_DIV)) : FRAC_W'(fsum);
    isum      = (IDX_W + 1)'(idx_r) + (IDX_W + 1)'(sidx_r) + (IDX_W + 1)'(carry);
    wrap_i    = isum >= (IDX_W + 1)'(WAVE_LENGTH);
    idx_nxt   = wrap_i ? IDX_W'(isum - (IDX_W + 1)'(WAVE_LENGTH)) : IDX_W'(isum);
    step_wrap = wrap_i || sbig_r;
  end

  // Divider step: one quotient bit, quotient also reduced modulo WAVE_LENGTH
  always_comb begin
    div_dvs     = div_vol_r ? DVS_W'(VOL_DIV) : DVS_W'(STEP_DIV);
    div_rsh     = {div_rem_r, div_num_r[DIV_W-1]};
    div_ge      = div_rsh >= {1'b0, div_dvs};
    div_rem_nxt = div_ge ? DVS_W'(div_rsh - {1'b0, div_dvs}) : DVS_W'(div_rsh);
    div_q_nxt   = {div_q_r[DIV_W-2:0], div_ge};
    div_qsh     = {div_qm_r, div_ge};
    div_qge     = div_qsh >= (IDX_W + 1)'(WAVE_LENGTH);
    div_qm_nxt  = div_qge ? IDX_W'(div_qsh - (IDX_W + 1)'(WAVE_LENGTH)) : IDX_W'(div_qsh);
  end

  // Scaling: divide by VOLUME_RESOLUTION*OVERSAMPLE toward zero, then saturate
  always_comb begin
    gain_s   = $signed({1'b0, gain_r});
    vbias    = prod_r[PROD_W-1] ? PROD_W'(VOL_DIV - 1) : '0;
    vq_fast  = (prod_r + vbias) >>> VOL_SH;
    mag      = prod_r[PROD_W-1] ? PROD_W'(-prod_r) : PROD_W'(prod_r);
    q_signed = neg_r ? -$signed({1'b0, div_q_nxt}) : $signed({1'b0, div_q_nxt});
    sat_in   = VOL_POW2 ? (DIV_W + 1)'(vq_fast) : q_signed;
    if (sat_in > SAT_HI) begin
      sat_out = 16'sh7FFF;
    end else if (sat_in < SAT_LO) begin
      sat_out = 16'sh8000;
    end else begin
      sat_out = SAMPLE_W'(sat_in);
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_tuser[0] == CMD_RENDER)) begin
          state_nxt = FAST_SPD ? S_RUN : S_SPDIV;
        end
      end
      S_SPDIV: begin
        if (div_cnt_r == '0) state_nxt = S_RUN;
      end
      S_RUN: begin
        if (cnt_r == CNT_W'(OS - 1)) state_nxt = S_DRAIN;
      end
      S_DRAIN: state_nxt = S_MUL;
      S_MUL:   state_nxt = S_SCALE;
      S_SCALE: state_nxt = VOL_POW2 ? S_OUT : S_VDIV;
      S_VDIV: begin
        if (div_cnt_r == '0) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control and oscillator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      idx_r      <= '0;
      frac_r     <= '0;
      cur_r      <= '0;
      pend_r     <= '0;
      rd_vld_r   <= 1'b0;
      out_tvalid <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= rd_en;

      // Wave selection on a render request
      if (in_acc && (in_tuser[0] == CMD_RENDER)) begin
        if (req.set_wave) cur_r <= req.wave_number;
        if (req.queue_wave) begin
          pend_r <= req.queued_number;
        end else if (req.set_wave) begin
          pend_r <= req.wave_number;
        end
      end

      // Phase advance and wave switch at wrap
      if (state_r == S_RUN) begin
        idx_r  <= idx_nxt;
        frac_r <= frac_nxt;
        if (step_wrap) cur_r <= pend_r;
      end

      // Output register
      if (out_load) begin
        out_tvalid <= 1'b1;
      end else if (out_tready) begin
        out_tvalid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    rd_ok_r <= 32'(cur_r) < WAVE_COUNT;

    if (in_acc) begin
      gain_r <= req.gain;
      en_r   <= req.enable;
      mix_r  <= req.mix_in;
      wrap_r <= 1'b0;
      acc_r  <= '0;
      cnt_r  <= '0;
      if (FAST_SPD) begin
        sidx_r  <= sidx_fast;
        sfrac_r <= sfrac_fast;
        sbig_r  <= sbig_fast;
      end
      // Divider loaded with the speed (used only when a divisor is not a power of two)
      div_num_r <= DIV_W'(req.speed);
      div_rem_r <= '0;
      div_q_r   <= '0;
      div_qm_r  <= '0;
      div_big_r <= 1'b0;
      div_vol_r <= 1'b0;
      div_cnt_r <= DCNT_W'(DIV_W - 1);
    end

    // Divider iteration
    if ((state_r == S_SPDIV) || (state_r == S_VDIV)) begin
      div_num_r <= {div_num_r[DIV_W-2:0], 1'b0};
      div_rem_r <= div_rem_nxt;
      div_q_r   <= div_q_nxt;
      div_qm_r  <= div_qm_nxt;
      div_big_r <= div_big_r || div_qge;
      div_cnt_r <= div_cnt_r - 1'b1;
    end

    // Speed split from the divider
    if ((state_r == S_SPDIV) && (div_cnt_r == '0)) begin
      sidx_r  <= div_qm_nxt;
      sfrac_r <= FRAC_W'(div_rem_nxt);
      sbig_r  <= div_big_r || div_qge;
    end

    if (state_r == S_RUN) begin
      cnt_r <= cnt_r + 1'b1;
      if (step_wrap) wrap_r <= 1'b1;
    end

    // Accumulate table words in the cycle after each read
    if (rd_vld_r && rd_ok_r) begin
      acc_r <= acc_r + SUM_W'(rd_data_r);
    end

    if (state_r == S_MUL) begin
      prod_r <= acc_r * gain_s;
    end

    // Scaling: direct when the divisor is a power of two, else through the divider
    if (state_r == S_SCALE) begin
      neg_r     <= prod_r[PROD_W-1];
      div_num_r <= DIV_W'(mag);
      div_rem_r <= '0;
      div_q_r   <= '0;
      div_qm_r  <= '0;
      div_big_r <= 1'b0;
      div_vol_r <= 1'b1;
      div_cnt_r <= DCNT_W'(DIV_W - 1);
      if (VOL_POW2) res_smp_r <= sat_out;
    end
    if ((state_r == S_VDIV) && (div_cnt_r == '0)) begin
      res_smp_r <= sat_out;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      res.pad     <= '0;
      res.wrapped <= wrap_r;
      res.sample  <= en_r ? res_smp_r : '0;
      res.mix_out <= mix_r + (en_r ? res_smp_r : '0);
    end
  end

  assign out_tdata = res;

  // A result only appears from the output stage
  a_out_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == S_OUT))
    else $error("result raised outside output stage");

  // Read data is only marked valid after a read cycle
  a_rd_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> $past(state_r == S_RUN))
    else $error("read data valid without a read");

  // Phase and step stay reduced while stepping
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> ((32'(idx_r) < WAVE_LENGTH) && (32'(frac_r) < STEP_DIV) &&
                            (32'(sidx_r) < WAVE_LENGTH) && (32'(sfrac_r) < STEP_DIV)))
    else $error("phase or step out of range");

  // A render request always starts the sequencer
  a_render_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_tuser[0] == CMD_RENDER)) |=> (state_r != S_IDLE))
    else $error("render request not started");

endmodule

`default_nettype wire

// ===== verif/oversampled_wavetable_oscillator_top_tb.sv =====
// Self-checking testbench for the oversampled wavetable oscillator top level.
// Needs wtosc_pkg and oversampled_wavetable_oscillator_top; table fill, directed rows,
// then random table writes and render requests checked against a local oscillator model.
`timescale 1ns / 1ps

module oversampled_wavetable_oscillator_top_tb;
  import wtosc_pkg::*;

  // Block geometry, as instantiated
  localparam int    WAVE_COUNT  = 16;
  localparam int    WAVE_LENGTH = 256;
  localparam longint OS_COUNT   = 4;
  localparam longint STEP_DIV   = 256 * OS_COUNT;
  localparam longint SPAN       = WAVE_LENGTH * STEP_DIV;
  localparam longint VOL_RES    = 256;

  // Waves that renders play; both are fully loaded before any render
  localparam int    WAVE_LO     = 0;
  localparam int    WAVE_HI     = WAVE_COUNT - 1;

  typedef struct {
    logic [0:0] cmd;
    in_req_t    req;
    bit         typed;
    out_res_t   want;
  } dir_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [0:0]             in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // Oscillator model state
  logic signed [15:0] wave_mem [WAVE_COUNT][WAVE_LENGTH];
  logic [17:0]        osc_phase;
  logic [3:0]         cur_wave;
  logic [3:0]         next_wave;

  out_res_t mix_exp_q[$];
  int       err_cnt = 0;
  int       burst_left = 0;
  int       rx_mode = 0;
  int       rx_left = 0;
  int       rx_tick = 0;
  out_res_t mon_got;
  out_res_t mon_want;

  oversampled_wavetable_oscillator_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // One rendered sample: wave select, oversampled reads with phase advance, scaling
  function automatic out_res_t osc_render(in_req_t r);
    out_res_t res;
    longint   acc_sum;
    longint   scaled;
    longint   nxt;
    longint   idx;
    int       s;
    res = '0;
    acc_sum = 0;
    scaled = 0;
    if (r.set_wave) begin
      cur_wave = r.wave_number;
      next_wave = r.wave_number;
    end
    if (r.queue_wave) next_wave = r.queued_number;
    for (s = 0; s < OS_COUNT; s++) begin
      idx = longint'(osc_phase) / STEP_DIV;
      acc_sum += longint'(wave_mem[cur_wave][idx]);
      nxt = longint'(osc_phase) + longint'(r.speed);
      if (nxt > SPAN - 1) begin
        nxt = nxt % SPAN;
        cur_wave = next_wave;
        res.wrapped = 1'b1;
      end
      osc_phase = nxt[17:0];
    end
    if (r.enable) begin
      scaled = acc_sum * longint'(r.gain);
      scaled = scaled / VOL_RES;
      scaled = scaled / OS_COUNT;
      if (scaled > 32767) scaled = 32767;
      if (scaled < -32768) scaled = -32768;
    end
    res.sample = scaled[15:0];
    scaled = longint'(r.mix_in) + scaled;
    res.mix_out = scaled[15:0];
    return res;
  endfunction

  function automatic dir_row_t stim_row(logic [0:0] cmd, int wave, int addr, int data,
                                        int speed, int gain, bit en, bit sw, bit qw,
                                        int qn, int mix, bit typed, int smp, int mout,
                                        bit wr);
    dir_row_t d;
    d.cmd = cmd;
    d.req = '0;
    d.req.wave_number = 4'(wave);
    d.req.table_addr = 8'(addr);
    d.req.table_data = 16'(data);
    d.req.speed = 24'(speed);
    d.req.gain = 9'(gain);
    d.req.enable = en;
    d.req.set_wave = sw;
    d.req.queue_wave = qw;
    d.req.queued_number = 4'(qn);
    d.req.mix_in = 16'(mix);
    d.typed = typed;
    d.want = '0;
    d.want.sample = 16'(smp);
    d.want.mix_out = 16'(mout);
    d.want.wrapped = wr;
    return d;
  endfunction

  // Drive one request, update the model on accept, then maybe idle for a while
  task automatic push_req(input logic [0:0] cmd, input in_req_t r, input bit typed,
                          input out_res_t want);
    out_res_t pred;
    int       gap;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= r;
    in_tuser <= cmd;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (cmd == CMD_RENDER) begin
      pred = osc_render(r);
      mix_exp_q.push_back(typed ? want : pred);
    end else begin
      wave_mem[r.wave_number][r.table_addr] = r.table_data;
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
      end
    end
  endtask

  // Sender holds off until every pending result has come back
  task automatic hold_until_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    wait (mix_exp_q.size() == 0);
  endtask

  // Receiver back-pressure: switches between free-running, random, heavy and periodic stalls
  always @(negedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_left <= $urandom_range(20, 300);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      2: out_tready <= ($urandom_range(0, 5) == 0);
      default: out_tready <= (rx_tick % 7) != 0;
    endcase
  end

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      mon_got = out_tdata;
      if (mix_exp_q.size() == 0) begin
        $error("result with no request pending: sample %0d mix_out %0d wrapped %0d",
               mon_got.sample, mon_got.mix_out, mon_got.wrapped);
        err_cnt++;
      end else begin
        mon_want = mix_exp_q.pop_front();
        if (mon_got.sample !== mon_want.sample) begin
          $error("sample: expected %0d, got %0d", mon_want.sample, mon_got.sample);
          err_cnt++;
        end
        if (mon_got.mix_out !== mon_want.mix_out) begin
          $error("mix_out: expected %0d, got %0d", mon_want.mix_out, mon_got.mix_out);
          err_cnt++;
        end
        if (mon_got.wrapped !== mon_want.wrapped) begin
          $error("wrapped: expected %0d, got %0d", mon_want.wrapped, mon_got.wrapped);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("oversampled_wavetable_oscillator_top: mismatch");
    $finish;
  end

  initial begin
    dir_row_t   dir_tbl[$];
    dir_row_t   d;
    in_req_t    r;
    logic [0:0] cmd;
    int         k;
    int         w;
    int         a;
    int         n;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = CMD_WRITE;
    out_tready = 1'b0;
    rst_n = 1'b0;
    osc_phase = '0;
    cur_wave = '0;
    next_wave = '0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Load both played waves so that no render reads an unwritten entry
    for (k = 0; k < 2; k++) begin
      w = (k == 0) ? WAVE_LO : WAVE_HI;
      for (a = 0; a < WAVE_LENGTH; a++) begin
        r = '0;
        r.wave_number = 4'(w);
        r.table_addr = 8'(a);
        r.table_data = 16'($urandom);
        r.speed = 24'($urandom);
        r.gain = 9'($urandom);
        r.mix_in = 16'($urandom);
        push_req(CMD_WRITE, r, 1'b0, '0);
      end
    end

    // Directed rows; phase is still 0 and wave 0 is current, so speed 0 reads word 0
    dir_tbl.push_back(stim_row(CMD_WRITE, 0, 0, 32767, 0, 0, 0, 0, 0, 0, 0,
                               0, 0, 0, 0));
    dir_tbl.push_back(stim_row(CMD_RENDER, 0, 0, 0, 0, 256, 1, 0, 0, 0, 0,
                               1, 32767, 32767, 0));
    // mix overflows and wraps
    dir_tbl.push_back(stim_row(CMD_RENDER, 0, 0, 0, 0, 256, 1, 0, 0, 0, 1,
                               1, 32767, -32768, 0));
    dir_tbl.push_back(stim_row(CMD_WRITE, 0, 0, -32768, 0, 0, 0, 0, 0, 0, 0,
                               0, 0, 0, 0));
    dir_tbl.push_back(stim_row(CMD_RENDER, 0, 0, 0, 0, 256, 1, 0, 0, 0, -1,
                               1, -32768, 32767, 0));
    // gain above unity saturates low
    dir_tbl.push_back(stim_row(CMD_RENDER, 0, 0, 0, 0, 511, 1, 0, 0, 0, 0,
                               1, -32768, -32768, 0));
    dir_tbl.push_back(stim_row(CMD_WRITE, 0, 0, 32767, 0, 0, 0, 0, 0, 0, 0,
                               0, 0, 0, 0));
    // and high
    dir_tbl.push_back(stim_row(CMD_RENDER, 0, 0, 0, 0, 511, 1, 0, 0, 0, -32768,
                               1, 32767, -1, 0));
    dir_tbl.push_back(stim_row(CMD_RENDER, 0, 0, 0, 0, 0, 1, 0, 0, 0, 100,
                               1, 0, 100, 0));
    // muted
    dir_tbl.push_back(stim_row(CMD_RENDER, 0, 0, 0, 0, 256, 0, 0, 0, 0, -5,
                               1, 0, -5, 0));
    // negative sum truncates toward zero: -1200/256 -> -4, /4 -> -1
    dir_tbl.push_back(stim_row(CMD_WRITE, 0, 0, -3, 0, 0, 0, 0, 0, 0, 0,
                               0, 0, 0, 0));
    dir_tbl.push_back(stim_row(CMD_RENDER, 0, 0, 0, 0, 100, 1, 0, 0, 0, 0,
                               1, -1, -1, 0));
    dir_tbl.push_back(stim_row(CMD_WRITE, 15, 255, -1, 0, 0, 0, 0, 0, 0, 0,
                               0, 0, 0, 0));
    dir_tbl.push_back(stim_row(CMD_WRITE, 15, 0, 21845, 0, 0, 0, 0, 0, 0, 0,
                               0, 0, 0, 0));
    // wave select and queue together, max speed wraps every step
    dir_tbl.push_back(stim_row(CMD_RENDER, 15, 0, 0, 24'hFFFFFF, 256, 1, 1, 1, 15, 32767,
                               0, 0, 0, 0));
    dir_tbl.push_back(stim_row(CMD_RENDER, 15, 0, 0, 0, 256, 1, 1, 0, 0, 0,
                               0, 0, 0, 0));
    dir_tbl.push_back(stim_row(CMD_RENDER, 0, 0, 0, 70000, 256, 1, 1, 1, 15, 0,
                               0, 0, 0, 0));
    dir_tbl.push_back(stim_row(CMD_RENDER, 0, 0, 0, 70000, 256, 1, 0, 0, 0, 0,
                               0, 0, 0, 0));
    dir_tbl.push_back(stim_row(CMD_RENDER, 0, 0, 0, 65536, 200, 1, 0, 1, 0, -32768,
                               0, 0, 0, 0));
    dir_tbl.push_back(stim_row(CMD_RENDER, 0, 0, 0, 262143, 256, 1, 0, 0, 0, 0,
                               0, 0, 0, 0));
    // one full span per step: wraps while the phase stays put
    dir_tbl.push_back(stim_row(CMD_RENDER, 0, 0, 0, 262144, 256, 1, 0, 0, 0, 0,
                               0, 0, 0, 0));
    dir_tbl.push_back(stim_row(CMD_RENDER, 0, 0, 0, 100000, 256, 0, 0, 1, 15, 1234,
                               0, 0, 0, 0));
    dir_tbl.push_back(stim_row(CMD_RENDER, 0, 0, 0, 1023, 257, 1, 1, 0, 0, -1,
                               0, 0, 0, 0));
    foreach (dir_tbl[i]) begin
      d = dir_tbl[i];
      push_req(d.cmd, d.req, d.typed, d.want);
    end
    hold_until_drained();

    // Random mix of table writes and renders; unused fields carry noise
    for (n = 0; n < 315; n++) begin
      r = '0;
      cmd = ($urandom_range(0, 3) == 0) ? CMD_WRITE : CMD_RENDER;
      // writes may hit any wave, renders only select the loaded ones
      if (cmd == CMD_WRITE) begin
        r.wave_number = 4'($urandom);
      end else begin
        r.wave_number = ($urandom_range(0, 1) == 0) ? 4'(WAVE_LO) : 4'(WAVE_HI);
      end
      r.table_addr = 8'($urandom);
      r.table_data = 16'($urandom);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: r.speed = 24'($urandom_range(0, 4095));
        6, 7: r.speed = 24'($urandom_range(4096, 262144));
        8: r.speed = 24'($urandom_range(262145, 24'hFFFFFF));
        default: r.speed = 24'($urandom);
      endcase
      r.gain = 9'(($urandom_range(0, 9) == 0) ? $urandom_range(257, 511) :
                                               $urandom_range(0, 256));
      r.enable = ($urandom_range(0, 7) != 0);
      r.set_wave = ($urandom_range(0, 9) == 0);
      r.queue_wave = ($urandom_range(0, 6) == 0);
      r.queued_number = ($urandom_range(0, 1) == 0) ? 4'(WAVE_LO) : 4'(WAVE_HI);
      r.mix_in = 16'($urandom);
      push_req(cmd, r, 1'b0, '0);
      if (n % 200 == 199) hold_until_drained();
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    wait (mix_exp_q.size() == 0);
    repeat (40) @(posedge clk);
    if (err_cnt == 0 && mix_exp_q.size() == 0) begin
      $display("oversampled_wavetable_oscillator_top: match");
    end else begin
      $display("oversampled_wavetable_oscillator_top: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/wtosc_pkg.sv
rtl/core/oversampled_wavetable_oscillator_top.sv
verif/oversampled_wavetable_oscillator_top_tb.sv
